[rtl/core/efgw_pkg.sv]
// Package for the event flag group with waiter table.
// Holds sizes, request and status codes, the waiter entry type and controller types.
// No dependencies.
`timescale 1ns / 1ps

package efgw_pkg;

   // sizes
   localparam int FLAG_BITS  = 32;
   localparam int WAIT_SLOTS = 8;
   localparam int CNT_W      = $clog2(WAIT_SLOTS + 1);
   localparam int IDX_W      = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

   // fixed field widths of the channel words
   localparam int MODE_W   = 3;
   localparam int PAT_W    = 32;
   localparam int TID_W    = 8;
   localparam int STATUS_W = 3;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TRY   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SEND  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RESET = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd4;

   // answer status codes
   localparam logic [STATUS_W-1:0] STAT_SUCCESS   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_UNAVAIL   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BLOCKED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NO_CHANGE = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_RESET     = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_FLUSH     = 3'd6;

   // one waiter slot
   typedef struct packed {
      logic [FLAG_BITS-1:0] bits;
      logic                 all;
      logic                 clears;
      logic [TID_W-1:0]     thread;
   } entry_type;

   // broadcast control to the cell chain
   typedef struct packed {
      logic      shift;
      entry_type load_entry;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINAL
   } state_type;

endpackage

[rtl/core/efgw_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on efgw_pkg.
`timescale 1ns / 1ps

interface efgw_req_if import efgw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [PAT_W-1:0]  pattern;
   logic              match_all;
   logic              consume;
   logic [TID_W-1:0]  requester_id;

   modport source (output valid, mode, pattern, match_all, consume, requester_id,
                   input ready);
   modport sink   (input valid, mode, pattern, match_all, consume, requester_id,
                   output ready);
endinterface

interface efgw_rsp_if import efgw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                for_waiter;
   logic [TID_W-1:0]    thread_id;
   logic [PAT_W-1:0]    matched;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, for_waiter, thread_id, matched, status, last,
                   input ready);
   modport sink   (input valid, for_waiter, thread_id, matched, status, last,
                   output ready);
endinterface

[rtl/core/efgw_cell.sv]
// One waiter slot of the cell chain: loads a new entry or takes its neighbor's.
// Depends on efgw_pkg.
`timescale 1ns / 1ps

module efgw_cell import efgw_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         load,
   input  entry_type    nbr_entry,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // tail load wins over the shift toward the head
   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = ctl.load_entry;
      end else if (ctl.shift) begin
         entry_in = nbr_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/core/efgw_ctrl.sv]
// Controller: flag word, waiter count, request decode, walk sequencer, response register.
// Depends on efgw_pkg and efgw_if; drives the cell chain and reads its head cell.
`timescale 1ns / 1ps

module efgw_ctrl import efgw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   efgw_req_if.sink              req_ch,
   efgw_rsp_if.source            rsp_ch,
   input  entry_type             head,
   output cell_ctl_type          ctl,
   output logic [WAIT_SLOTS-1:0] load_vec
);

   state_type            state_ff, state_in;
   logic [FLAG_BITS-1:0] flag_ff, flag_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic                 stop_ff, stop_in;
   logic [MODE_W-1:0]    op_ff, op_in;
   logic [TID_W-1:0]     rid_ff, rid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fw_ff;
   logic [TID_W-1:0]     rsp_tid_ff;
   logic [PAT_W-1:0]     rsp_matched_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_last_ff;

   logic                 out_free;
   logic [FLAG_BITS-1:0] req_pat, rx_hit, head_hit, head_left;
   logic                 rx_ok, head_ok;
   logic [CNT_W-1:0]     cnt_dec;

   logic                 emit;
   logic                 e_fw, e_last;
   logic [TID_W-1:0]     e_tid;
   logic [PAT_W-1:0]     e_matched;
   logic [STATUS_W-1:0]  e_status;
   logic                 load_en;
   logic [IDX_W-1:0]     load_idx;

   // match tests for the caller and for the head waiter
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_pat   = FLAG_BITS'(req_ch.pattern);
   assign rx_hit    = flag_ff & req_pat;
   assign rx_ok     = req_ch.match_all ? (rx_hit == req_pat) : (|rx_hit);
   assign head_hit  = flag_ff & head.bits;
   assign head_ok   = head.all ? (head_hit == head.bits) : (|head_hit);
   assign head_left = flag_ff & ~head_hit;
   assign cnt_dec   = count_ff - CNT_W'(1);

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      flag_in        = flag_ff;
      count_in       = count_ff;
      steps_in       = steps_ff;
      stop_in        = stop_ff;
      op_in          = op_ff;
      rid_in         = rid_ff;
      req_ch.ready   = 1'b0;
      emit           = 1'b0;
      e_fw           = 1'b0;
      e_tid          = rid_ff;
      e_matched      = '0;
      e_status       = STAT_SUCCESS;
      e_last         = 1'b1;
      ctl.shift      = 1'b0;
      ctl.load_entry = head;
      load_en        = 1'b0;
      load_idx       = count_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = out_free;
            if (req_ch.valid && out_free) begin
               emit  = 1'b1;
               e_tid = req_ch.requester_id;
               unique case (req_ch.mode) inside
                  MODE_TRY, MODE_WAIT: begin
                     if (rx_ok) begin
                        e_matched = PAT_W'(rx_hit);
                        if (req_ch.consume) begin
                           flag_in = flag_ff & ~rx_hit;
                        end
                     end else if (req_ch.mode == MODE_TRY) begin
                        e_status = STAT_UNAVAIL;
                     end else if (count_ff < CNT_W'(WAIT_SLOTS)) begin
                        // join the table at its tail
                        load_en                  = 1'b1;
                        ctl.load_entry.bits      = req_pat;
                        ctl.load_entry.all       = req_ch.match_all;
                        ctl.load_entry.clears    = req_ch.consume;
                        ctl.load_entry.thread    = req_ch.requester_id;
                        count_in                 = count_ff + CNT_W'(1);
                        e_status                 = STAT_BLOCKED;
                     end else begin
                        e_status = STAT_FULL;
                     end
                  end
                  MODE_SEND: begin
                     if ((flag_ff | req_pat) == flag_ff) begin
                        e_status = STAT_NO_CHANGE;
                     end else begin
                        flag_in = flag_ff | req_pat;
                        if (count_ff != '0) begin
                           emit     = 1'b0;
                           steps_in = count_ff;
                           stop_in  = 1'b0;
                           op_in    = req_ch.mode;
                           rid_in   = req_ch.requester_id;
                           state_in = ST_WALK;
                        end
                     end
                  end
                  MODE_RESET, MODE_FLUSH: begin
                     if (req_ch.mode == MODE_RESET) begin
                        flag_in = '0;
                     end
                     if (count_ff != '0) begin
                        emit     = 1'b0;
                        steps_in = count_ff;
                        stop_in  = 1'b0;
                        op_in    = req_ch.mode;
                        rid_in   = req_ch.requester_id;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     e_status = STAT_UNAVAIL;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // one slot per cycle leaves the head while the response register is free; kept slots rotate to the tail
            if (out_free) begin
               ctl.shift = 1'b1;
               steps_in  = steps_ff - CNT_W'(1);
               if (steps_ff == CNT_W'(1)) begin
                  state_in = ST_FINAL;
               end
               e_fw   = 1'b1;
               e_tid  = head.thread;
               e_last = 1'b0;
               if (op_ff == MODE_SEND) begin
                  if (!stop_ff && head_ok) begin
                     emit      = 1'b1;
                     e_matched = PAT_W'(head_hit);
                     count_in  = cnt_dec;
                     if (head.clears) begin
                        flag_in = head_left;
                        stop_in = (head_left == '0);
                     end
                  end else begin
                     load_en  = 1'b1;
                     load_idx = cnt_dec[IDX_W-1:0];
                  end
               end else begin
                  emit     = 1'b1;
                  e_status = (op_ff == MODE_RESET) ? STAT_RESET : STAT_FLUSH;
                  count_in = cnt_dec;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // one-hot tail load select
   always_comb begin
      for (int i = 0; i < WAIT_SLOTS; i++) begin
         load_vec[i] = load_en && (load_idx == IDX_W'(i));
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= '0;
         count_ff     <= '0;
         steps_ff     <= '0;
         stop_ff      <= 1'b0;
         op_ff        <= MODE_TRY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         stop_ff      <= stop_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response word and caller identity
   always_ff @(posedge clock) begin
      rid_ff <= rid_in;
      if (emit) begin
         rsp_fw_ff      <= e_fw;
         rsp_tid_ff     <= e_tid;
         rsp_matched_ff <= e_matched;
         rsp_status_ff  <= e_status;
         rsp_last_ff    <= e_last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.for_waiter = rsp_fw_ff;
   assign rsp_ch.thread_id  = rsp_tid_ff;
   assign rsp_ch.matched    = rsp_matched_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WAIT_SLOTS))
      else $error("waiter count beyond table size");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> steps_ff <= count_ff && steps_ff != '0)
      else $error("walk steps out of step with waiter count");

   a_walk_no_growth: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |=> count_ff <= $past(count_ff))
      else $error("waiter table grew during a walk");

   a_release_all: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL && op_ff != MODE_SEND |-> count_ff == '0)
      else $error("reset or flush left waiters behind");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.mode == MODE_RESET |=> flag_ff == '0)
      else $error("flag word not cleared by reset request");

endmodule

[rtl/core/event_flag_group_waiters_top.sv]
// Top level of the event flag group: controller plus a chain of waiter cells.
// Depends on efgw_pkg, efgw_if, efgw_cell, efgw_ctrl.
//
//   channel   direction  handshake     word fields
//   req_ch    in         valid/ready   mode, pattern, match_all, consume, requester_id
//   rsp_ch    out        valid/ready   for_waiter, thread_id, matched, status, last
//
// Receive, try, send without new bits, unknown modes and any request with an empty
// table: answered straight from the idle state.
// Send with new bits, reset or flush with n > 0 waiters: accept, then a walk in
// which the chain shifts each slot from its head cell into the controller, then the
// caller answer.
// Synchronous reset clears the flags, the waiter count and the response valid bit.
// A response that is not taken holds the walk; no request is taken during a walk.
`timescale 1ns / 1ps

module event_flag_group_waiters_top import efgw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   efgw_req_if.sink   req_ch,
   efgw_rsp_if.source rsp_ch
);

   cell_ctl_type          ctl;
   logic [WAIT_SLOTS-1:0] load_vec;
   entry_type             cell_q [WAIT_SLOTS];

   efgw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .head     (cell_q[0]),
      .ctl      (ctl),
      .load_vec (load_vec)
   );

   // cell chain: each cell but the last takes its upper neighbor on a shift; the last keeps its own
   for (genvar i = 0; i < WAIT_SLOTS; i++) begin : g_cell
      if (i == WAIT_SLOTS - 1) begin : g_end
         efgw_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .load      (load_vec[i]),
            .nbr_entry (cell_q[i]),
            .entry     (cell_q[i])
         );
      end else begin : g_mid
         efgw_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .load      (load_vec[i]),
            .nbr_entry (cell_q[i+1]),
            .entry     (cell_q[i])
         );
      end
   end

endmodule
